// ----- hdl/apsp_pkg.sv -----
// Shared types and constants of the all-pairs shortest path block.
package apsp_pkg;

  localparam int NODE_ID_W    = 7;
  localparam int WEIGHT_W     = 20;
  localparam int OUT_DIST_W   = 32;
  localparam int NODE_COUNT_W = 8;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 2;

  localparam logic [CFG_ADDR_W-1:0]   REG_NODE_COUNT_ADDR = 2'd0;
  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET    = 8'd128;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_EDGE  = 2'd1,
    FUNC_RUN   = 2'd2,
    FUNC_QUERY = 2'd3
  } func_t;

  typedef struct packed {
    func_t                func;
    logic [NODE_ID_W-1:0] node_a;
    logic [NODE_ID_W-1:0] node_b;
    logic [WEIGHT_W-1:0]  weight;
  } in_item_t;

  typedef struct packed {
    logic [OUT_DIST_W-1:0] distance;
    logic                  reachable;
  } out_item_t;

  // Query response handed from the sequencer to the output register
  typedef struct packed {
    logic      load;
    out_item_t item;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EDGE2,
    ST_QREAD,
    ST_QRESP,
    ST_ROWHEAD,
    ST_ROWWAIT,
    ST_SCAN,
    ST_DRAIN
  } seq_state_t;

endpackage

// ----- hdl/apsp_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module apsp_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// ----- hdl/apsp_seq.sv -----
// Sequencer: clear sweep, edge writes, queries and the closure scan over the matrix RAM.
module apsp_seq
  import apsp_pkg::*;
#(
  parameter int MAX_NODES = 128,
  parameter int DIST_BITS = 32,
  localparam int NODE_W   = $clog2(MAX_NODES),
  localparam int ADDR_W   = 2 * NODE_W,
  localparam int WORD_W   = DIST_BITS + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [NODE_COUNT_W-1:0] node_count,
  input  logic                    in_valid,
  input  in_item_t                in_data,
  output logic                    in_ready,
  input  logic                    out_free,
  output res_t                    res,
  output logic                    mem_we,
  output logic [ADDR_W-1:0]       mem_waddr,
  output logic [WORD_W-1:0]       mem_wdata,
  output logic [ADDR_W-1:0]       mem_ra_addr,
  input  logic [WORD_W-1:0]       mem_ra_data,
  output logic [ADDR_W-1:0]       mem_rb_addr,
  input  logic [WORD_W-1:0]       mem_rb_data
);

  localparam int CW = (NODE_W + 1 > NODE_COUNT_W) ? NODE_W + 1 : NODE_COUNT_W;
  localparam int WX = (DIST_BITS > WEIGHT_W) ? DIST_BITS : WEIGHT_W;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [NODE_W-1:0] row,
                                                  input logic [NODE_W-1:0] col);
    return {row, col};
  endfunction

  function automatic logic [DIST_BITS-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
    logic [WX-1:0] w_x;
    w_x = WX'(w);
    return (w_x > WX'(DIST_MAX)) ? DIST_MAX : w_x[DIST_BITS-1:0];
  endfunction

  function automatic logic node_ok(input logic [NODE_ID_W-1:0] id);
    return 32'(id) < 32'(MAX_NODES);
  endfunction

  seq_state_t           state_r, state_nxt;
  logic [CW-1:0]        via_r, via_nxt;
  logic [CW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  in_item_t             item_r, item_nxt;
  logic [DIST_BITS-1:0] rk_r, rk_nxt;
  logic                 pend_r, pend_nxt;
  logic [NODE_W-1:0]    pend_col_r, pend_col_nxt;

  logic [CW-1:0]        n_act;
  logic [CW-1:0]        n_last;
  logic                 row_last, col_last, via_last;
  logic                 kc_reach, rc_reach;
  logic [DIST_BITS-1:0] kc_dist, rc_dist;
  logic [DIST_BITS:0]   sum_x;
  logic [DIST_BITS-1:0] sum_sat;
  logic                 relax_hit;
  logic                 query_ok;

  assign n_act    = (CW'(node_count) > CW'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(node_count);
  assign n_last   = n_act - CW'(1);
  assign row_last = (row_r == n_last);
  assign col_last = (col_r == n_last);
  assign via_last = (via_r == n_last);

  // Relaxation of the entry read in the previous cycle of the scan
  assign kc_reach  = mem_ra_data[DIST_BITS];
  assign kc_dist   = mem_ra_data[DIST_BITS-1:0];
  assign rc_reach  = mem_rb_data[DIST_BITS];
  assign rc_dist   = mem_rb_data[DIST_BITS-1:0];
  assign sum_x     = {1'b0, rk_r} + {1'b0, kc_dist};
  assign sum_sat   = sum_x[DIST_BITS] ? DIST_MAX : sum_x[DIST_BITS-1:0];
  assign relax_hit = pend_r && kc_reach && (!rc_reach || (sum_sat < rc_dist));

  assign query_ok = node_ok(item_r.node_a) && node_ok(item_r.node_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      via_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      via_r   <= via_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rk_r       <= rk_nxt;
    pend_col_r <= pend_col_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    via_nxt      = via_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    item_nxt     = item_r;
    rk_nxt       = rk_r;
    pend_nxt     = 1'b0;
    pend_col_nxt = pend_col_r;
    in_ready     = 1'b0;
    res          = '0;
    mem_we       = 1'b0;
    mem_waddr    = cell_addr(row_r[NODE_W-1:0], pend_col_r);
    mem_wdata    = {1'b1, sum_sat};
    mem_ra_addr  = cell_addr(row_r[NODE_W-1:0], via_r[NODE_W-1:0]);
    mem_rb_addr  = cell_addr(row_r[NODE_W-1:0], col_r[NODE_W-1:0]);

    // Write back an improved entry from the scan pipeline
    if (relax_hit) begin
      mem_we = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          via_nxt  = '0;
          row_nxt  = '0;
          col_nxt  = '0;
          case (in_data.func)
            FUNC_CLEAR: begin
              if (n_act != '0) begin
                state_nxt = ST_CLEAR;
              end
            end
            FUNC_EDGE: begin
              if (node_ok(in_data.node_a) && node_ok(in_data.node_b)) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(NODE_W'(in_data.node_a), NODE_W'(in_data.node_b));
                mem_wdata = {1'b1, sat_weight(in_data.weight)};
                state_nxt = ST_EDGE2;
              end
            end
            FUNC_RUN: begin
              if (n_act != '0) begin
                state_nxt = ST_ROWHEAD;
              end
            end
            FUNC_QUERY: begin
              state_nxt = ST_QREAD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(row_r[NODE_W-1:0], col_r[NODE_W-1:0]);
        mem_wdata = {(row_r == col_r), {DIST_BITS{1'b0}}};
        if (col_last) begin
          col_nxt = '0;
          if (row_last) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt = row_r + CW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end

      ST_EDGE2: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(NODE_W'(item_r.node_b), NODE_W'(item_r.node_a));
        mem_wdata = {1'b1, sat_weight(item_r.weight)};
        state_nxt = ST_IDLE;
      end

      ST_QREAD: begin
        // Hold until the output register has room for the response
        mem_ra_addr = cell_addr(NODE_W'(item_r.node_a), NODE_W'(item_r.node_b));
        if (out_free) begin
          state_nxt = ST_QRESP;
        end
      end

      ST_QRESP: begin
        res.load = 1'b1;
        if (query_ok && mem_ra_data[DIST_BITS]) begin
          res.item.reachable = 1'b1;
          res.item.distance  = OUT_DIST_W'(mem_ra_data[DIST_BITS-1:0]);
        end
        state_nxt = ST_IDLE;
      end

      ST_ROWHEAD: begin
        state_nxt = ST_ROWWAIT;
      end

      ST_ROWWAIT: begin
        if (mem_ra_data[DIST_BITS]) begin
          rk_nxt    = mem_ra_data[DIST_BITS-1:0];
          col_nxt   = '0;
          state_nxt = ST_SCAN;
        end else if (!row_last) begin
          row_nxt   = row_r + CW'(1);
          state_nxt = ST_ROWHEAD;
        end else if (!via_last) begin
          row_nxt   = '0;
          via_nxt   = via_r + CW'(1);
          state_nxt = ST_ROWHEAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN: begin
        mem_ra_addr  = cell_addr(via_r[NODE_W-1:0], col_r[NODE_W-1:0]);
        pend_nxt     = 1'b1;
        pend_col_nxt = col_r[NODE_W-1:0];
        if (col_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end

      ST_DRAIN: begin
        if (!row_last) begin
          row_nxt   = row_r + CW'(1);
          state_nxt = ST_ROWHEAD;
        end else if (!via_last) begin
          row_nxt   = '0;
          via_nxt   = via_r + CW'(1);
          state_nxt = ST_ROWHEAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("relaxation pending outside the scan");

  a_scan_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_SCAN) |-> (mem_waddr != mem_rb_addr))
    else $error("scan write-back hits the entry being read");

  a_resp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QRESP) |-> ($past(state_r) == ST_QREAD && $past(out_free)))
    else $error("query response without a matching read");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == ST_IDLE) |-> (in_valid && in_data.func == FUNC_EDGE))
    else $error("matrix write while idle without an edge transaction");

endmodule

// ----- hdl/all_pairs_shortest_path.sv -----
// Top level of the all-pairs shortest path block: config register, output register, RAM, sequencer.
//
//   Channel  Dir  Handshake                      Payload
//   in_      in   in_valid / in_ready            in_item_t  (func, node_a, node_b, weight)
//   out_     out  out_valid / out_ready          out_item_t (distance, reachable)
//   cfg      in   psel/penable/pwrite, pready=1  node_count at byte address 0
//
// Work: an edge writes both mirrored entries, a query waits for the output register, a clear
// sweeps all n*n entries, and a run is the closure scan with n = min(node_count, MAX_NODES),
// one relaxation per cycle within a row through the two-read, one-write matrix RAM.
// Reset: rst_n synchronous, active low; clears control and sets node_count to 128.
// Matrix contents are undefined until written by a clear or an edge transaction.
// Stalls: in_ready is low while an item is in work; a waiting result does not block
// non-query items, and a query waits only for the output register to free up.
module all_pairs_shortest_path
  import apsp_pkg::*;
#(
  parameter int MAX_NODES = 128,
  parameter int DIST_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int ADDR_W = 2 * NODE_W;
  localparam int WORD_W = DIST_BITS + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic [NODE_COUNT_W-1:0] node_count_r, node_count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;
  logic                    cfg_write;
  logic                    out_free;
  res_t                    res;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_ra_addr;
  logic [WORD_W-1:0] mem_ra_data;
  logic [ADDR_W-1:0] mem_rb_addr;
  logic [WORD_W-1:0] mem_rb_data;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == REG_NODE_COUNT_ADDR) ? CFG_DATA_W'(node_count_r) : '0;

  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_write) begin
      node_count_nxt = pwdata[NODE_COUNT_W-1:0];
    end
  end

  // Output register
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      node_count_r <= node_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  apsp_seq #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .node_count  (node_count_r),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .in_ready    (in_ready),
    .out_free    (out_free),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_ra_addr (mem_ra_addr),
    .mem_ra_data (mem_ra_data),
    .mem_rb_addr (mem_rb_addr),
    .mem_rb_data (mem_rb_data)
  );

  apsp_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (mem_ra_addr),
    .ra_data (mem_ra_data),
    .rb_addr (mem_rb_addr),
    .rb_data (mem_rb_data)
  );

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> !out_valid_r)
    else $error("query response overwrites a result still waiting");

endmodule
